/* rtl/tds_pkg.sv */
// Shared types and constants of the task dependency scoreboard.
package tds_pkg;

   localparam int SLOT_W  = 5;
   localparam int OP_W    = 3;
   localparam int MASK_W  = 32;
   localparam int COUNT_W = 6;
   localparam int REQ_W   = 48;
   localparam int RSP_W   = 72;

   typedef enum logic [2:0] {
      ST_PENDING   = 3'd0,
      ST_READY     = 3'd1,
      ST_RUNNING   = 3'd2,
      ST_COMPLETED = 3'd3,
      ST_FAILED    = 3'd4
   } status_type;

   typedef enum logic [OP_W-1:0] {
      OP_ADD_TASK     = 3'd0,
      OP_ADD_EDGE     = 3'd1,
      OP_MARK_RUNNING = 3'd2,
      OP_MARK_DONE    = 3'd3,
      OP_MARK_FAILED  = 3'd4,
      OP_RESET_FAILED = 3'd5,
      OP_REOPEN       = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_SEED,
      ACT_STEP,
      ACT_ADD,
      ACT_EDGE,
      ACT_STATUS,
      ACT_REOPEN,
      ACT_REFRESH
   } action_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_WALK,
      S_APPLY,
      S_REFRESH,
      S_REPORT
   } state_type;

   typedef struct packed {
      action_type            action;
      logic [SLOT_W-1:0]     slot;
      status_type            status;
   } cell_ctl_type;

endpackage

/* rtl/tds_cell.sv */
// One task slot: valid flag, status, prerequisite row and reachability bit.
module tds_cell #(
   parameter int NUM_CELLS = 32,
   parameter int INDEX     = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tds_pkg::cell_ctl_type  ctl,
   input  logic [NUM_CELLS-1:0]   vec,
   output logic                   valid,
   output tds_pkg::status_type    status,
   output logic                   reach
);
   import tds_pkg::*;

   logic                 valid_ff, valid_in;
   status_type           status_ff, status_in;
   logic [NUM_CELLS-1:0] row_ff, row_in;
   logic                 reach_ff, reach_in;
   logic                 sel;

   assign sel = (int'(ctl.slot) == INDEX);

   always_comb begin
      valid_in  = valid_ff;
      status_in = status_ff;
      row_in    = row_ff;
      reach_in  = reach_ff;
      case (ctl.action)
         ACT_SEED: begin
            reach_in = sel;
         end
         ACT_STEP: begin
            // A valid task that depends on anything already reached joins the set.
            if (valid_ff && (row_ff & vec) != '0) begin
               reach_in = 1'b1;
            end
         end
         ACT_ADD: begin
            if (sel) begin
               valid_in  = 1'b1;
               status_in = ST_PENDING;
               row_in    = vec;
            end
         end
         ACT_EDGE: begin
            if (sel) begin
               row_in = row_ff | vec;
            end
         end
         ACT_STATUS: begin
            if (sel) begin
               status_in = ctl.status;
            end
         end
         ACT_REOPEN: begin
            if (valid_ff && reach_ff) begin
               status_in = ST_PENDING;
            end
         end
         ACT_REFRESH: begin
            // Here vec carries the set of completed tasks.
            if (valid_ff && (status_ff == ST_PENDING || status_ff == ST_READY)) begin
               status_in = ((row_ff & ~vec) == '0) ? ST_READY : ST_PENDING;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      status_ff <= status_in;
      row_ff    <= row_in;
      reach_ff  <= reach_in;
   end

   assign valid  = valid_ff;
   assign status = status_ff;
   assign reach  = reach_ff;

endmodule

/* rtl/task_dependency_scoreboard_unit.sv */
// Task dependency scoreboard: a row of slot cells driven by one sequencer.
//
// Input channel req_*: one word per operation (add task, add edge, mark
// running, completed or failed, reset failed, reopen). Result channel rsp_*:
// one word per operation with the accepted flag, the ready and failed masks,
// the unfinished flag and the task count after the operation.
// Sequence: an operation is taken in the idle state, checked, applied and
// followed by a ready refresh, then its result word is built; the next word
// is taken only once the sequencer is back in idle. Add edge and reopen,
// when their checks pass, also run a reachability walk over the cells
// between the check and the apply step, one frontier expansion per cycle,
// MAX_TASKS expansions in all.
// The result sits in an output register; while the receiver stalls the next
// word is already accepted and worked on, and it waits in its last step
// until the output register is free.
// Reset clears all slots (no valid tasks, count zero) and empties the
// output register; the block takes a word in the cycle after reset.
module task_dependency_scoreboard_unit #(
   parameter int MAX_TASKS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // op[2:0], task_slot[7:3], from_slot[12:8], dep_mask[44:13], zero pad
   input  logic [tds_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // accepted[0], ready_mask[32:1], failed_mask[64:33], any_unfinished[65],
   // task_count[71:66]
   output logic [tds_pkg::RSP_W-1:0]   rsp_tdata
);
   import tds_pkg::*;

   localparam int WIDE  = (MAX_TASKS > MASK_W) ? MAX_TASKS : MASK_W;
   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   state_type            state_ff, state_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [SLOT_W-1:0]    t_ff, t_in;
   logic [SLOT_W-1:0]    f_ff, f_in;
   logic [MASK_W-1:0]    deps_ff, deps_in;
   logic                 ok_ff, ok_in;
   logic [CNT_W-1:0]     walk_ff, walk_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]     rsp_data_ff, rsp_data_in;

   cell_ctl_type         ctl;
   logic [MAX_TASKS-1:0] vec;
   logic [MAX_TASKS-1:0] valid_vec, reach_vec;
   status_type           cell_status [MAX_TASKS];

   logic [MAX_TASKS-1:0] t_oh, f_oh, done_vec, ready_vec, failed_vec, deps_n;
   logic [WIDE-1:0]      deps_wide, ready_wide, failed_wide;
   logic [2:0]           st_t_bits;
   status_type           st_t;
   logic                 t_in_range, t_ok, f_ok, deps_ok, pre_ok, unfinished;

   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      tds_cell #(
         .NUM_CELLS (MAX_TASKS),
         .INDEX     (i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl),
         .vec    (vec),
         .valid  (valid_vec[i]),
         .status (cell_status[i]),
         .reach  (reach_vec[i])
      );
   end

   // Per-slot views of the cells and of the held operation.
   always_comb begin
      st_t_bits = '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
         t_oh[i]       = (int'(t_ff) == i);
         f_oh[i]       = (int'(f_ff) == i);
         done_vec[i]   = valid_vec[i] && (cell_status[i] == ST_COMPLETED);
         ready_vec[i]  = valid_vec[i] && (cell_status[i] == ST_READY);
         failed_vec[i] = valid_vec[i] && (cell_status[i] == ST_FAILED);
         st_t_bits     = st_t_bits | ({3{t_oh[i]}} & cell_status[i]);
      end
   end

   assign st_t        = status_type'(st_t_bits);
   assign deps_wide   = WIDE'(deps_ff);
   assign deps_n      = deps_wide[MAX_TASKS-1:0];
   assign ready_wide  = WIDE'(ready_vec);
   assign failed_wide = WIDE'(failed_vec);
   assign unfinished  = (valid_vec & ~done_vec) != '0;

   assign t_in_range = int'(t_ff) < MAX_TASKS;
   assign t_ok       = t_in_range && ((valid_vec & t_oh) != '0);
   assign f_ok       = (int'(f_ff) < MAX_TASKS) && ((valid_vec & f_oh) != '0);
   assign deps_ok    = ((deps_wide >> MAX_TASKS) == '0) && ((deps_n & t_oh) == '0)
                       && ((deps_n & ~valid_vec) == '0);

   always_comb begin
      case (op_type'(op_ff))
         OP_ADD_TASK:     pre_ok = t_in_range && ((valid_vec & t_oh) == '0) && deps_ok;
         OP_ADD_EDGE:     pre_ok = t_ok && f_ok && (f_ff != t_ff);
         OP_MARK_RUNNING: pre_ok = t_ok && (st_t == ST_READY);
         OP_MARK_DONE,
         OP_MARK_FAILED:  pre_ok = t_ok && (st_t == ST_READY || st_t == ST_RUNNING);
         OP_RESET_FAILED: pre_ok = t_ok && (st_t == ST_FAILED);
         OP_REOPEN:       pre_ok = t_ok;
         default:         pre_ok = 1'b0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      t_in         = t_ff;
      f_in         = f_ff;
      deps_in      = deps_ff;
      ok_in        = ok_ff;
      walk_in      = walk_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = (state_ff == S_IDLE) && !reset;
      ctl.action   = ACT_NONE;
      ctl.slot     = t_ff;
      ctl.status   = ST_PENDING;
      vec          = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tdata[2:0];
               t_in     = req_tdata[7:3];
               f_in     = req_tdata[12:8];
               deps_in  = req_tdata[44:13];
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            ok_in   = pre_ok;
            walk_in = '0;
            if (pre_ok && (op_type'(op_ff) == OP_ADD_EDGE || op_type'(op_ff) == OP_REOPEN)) begin
               ctl.action = ACT_SEED;
               state_in   = S_WALK;
            end else begin
               state_in = S_APPLY;
            end
         end
         S_WALK: begin
            ctl.action = ACT_STEP;
            vec        = reach_vec;
            walk_in    = walk_ff + 1'b1;
            if (walk_ff == CNT_W'(MAX_TASKS - 1)) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            state_in = S_REFRESH;
            if (ok_ff) begin
               case (op_type'(op_ff))
                  OP_ADD_TASK: begin
                     ctl.action = ACT_ADD;
                     vec        = deps_n;
                     count_in   = count_ff + 1'b1;
                  end
                  OP_ADD_EDGE: begin
                     // Reaching the prerequisite from the target means a cycle.
                     if ((reach_vec & f_oh) != '0) begin
                        ok_in = 1'b0;
                     end else begin
                        ctl.action = ACT_EDGE;
                        vec        = f_oh;
                     end
                  end
                  OP_MARK_RUNNING: begin
                     ctl.action = ACT_STATUS;
                     ctl.status = ST_RUNNING;
                  end
                  OP_MARK_DONE: begin
                     ctl.action = ACT_STATUS;
                     ctl.status = ST_COMPLETED;
                  end
                  OP_MARK_FAILED: begin
                     ctl.action = ACT_STATUS;
                     ctl.status = ST_FAILED;
                  end
                  OP_RESET_FAILED: begin
                     ctl.action = ACT_STATUS;
                     ctl.status = ST_PENDING;
                  end
                  OP_REOPEN: begin
                     ctl.action = ACT_REOPEN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_REFRESH: begin
            ctl.action = ACT_REFRESH;
            vec        = done_vec;
            state_in   = S_REPORT;
         end
         S_REPORT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {count_ff, unfinished, failed_wide[MASK_W-1:0],
                               ready_wide[MASK_W-1:0], ok_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      t_ff        <= t_in;
      f_ff        <= f_in;
      deps_ff     <= deps_in;
      ok_ff       <= ok_in;
      walk_ff     <= walk_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* tb/task_dependency_scoreboard_unit_tb.sv */
// Self-checking testbench for the task dependency scoreboard unit.
`timescale 1ns / 100ps

module task_dependency_scoreboard_unit_tb;
   import tds_pkg::*;

   localparam int NUM_SLOTS      = 32;
   localparam int RANDOM_WORDS   = 950;
   localparam int QUIET_LIMIT    = 5000;
   localparam int DRAIN_CYCLES   = 48;
   localparam logic [OP_W-1:0] OP_UNDEFINED = 3'd7;

   // Result word layout, highest field first.
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               unfinished;
      logic [MASK_W-1:0]  failed;
      logic [MASK_W-1:0]  ready;
      logic               accepted;
   } outcome_type;

   class dag_scoreboard;
      bit                slot_used[NUM_SLOTS];
      status_type        slot_state[NUM_SLOTS];
      logic [MASK_W-1:0] prereqs[NUM_SLOTS];
      outcome_type       expected_q[$];
      int                mismatches;

      function new();
         for (int s = 0; s < NUM_SLOTS; s++) begin
            slot_used[s]  = 1'b0;
            slot_state[s] = ST_PENDING;
            prereqs[s]    = '0;
         end
         mismatches = 0;
      endfunction

      function logic [MASK_W-1:0] valid_bits();
         logic [MASK_W-1:0] m;
         m = '0;
         for (int s = 0; s < NUM_SLOTS; s++) m[s] = slot_used[s];
         return m;
      endfunction

      function logic [MASK_W-1:0] slots_in(status_type st);
         logic [MASK_W-1:0] m;
         m = '0;
         for (int s = 0; s < NUM_SLOTS; s++) m[s] = slot_used[s] && slot_state[s] == st;
         return m;
      endfunction

      // The start slot plus every valid slot that depends on it through any chain.
      function logic [MASK_W-1:0] reach_from(int start);
         logic [MASK_W-1:0] reach, prev;
         reach = '0;
         reach[start] = 1'b1;
         for (int pass = 0; pass < NUM_SLOTS; pass++) begin
            prev = reach;
            for (int s = 0; s < NUM_SLOTS; s++)
               if (slot_used[s] && (prereqs[s] & reach) != 0) reach[s] = 1'b1;
            if (reach == prev) break;
         end
         return reach;
      endfunction

      function void refresh_ready();
         logic [MASK_W-1:0] done;
         done = slots_in(ST_COMPLETED);
         for (int s = 0; s < NUM_SLOTS; s++)
            if (slot_used[s] && (slot_state[s] == ST_PENDING || slot_state[s] == ST_READY))
               slot_state[s] = ((prereqs[s] & ~done) == 0) ? ST_READY : ST_PENDING;
      endfunction

      function void note_request(logic [REQ_W-1:0] w);
         logic [OP_W-1:0]   op;
         logic [MASK_W-1:0] deps, reach;
         int                tgt, src;
         bit                ok;
         outcome_type       o;
         op   = w[2:0];
         tgt  = w[7:3];
         src  = w[12:8];
         deps = w[44:13];
         ok   = 1'b0;
         case (op)
            OP_ADD_TASK:
               if (!slot_used[tgt] && !deps[tgt] && (deps & ~valid_bits()) == 0) begin
                  slot_used[tgt]  = 1'b1;
                  slot_state[tgt] = ST_PENDING;
                  prereqs[tgt]    = deps;
                  refresh_ready();
                  ok = 1'b1;
               end
            OP_ADD_EDGE:
               if (slot_used[tgt] && slot_used[src] && src != tgt) begin
                  if (prereqs[tgt][src]) begin
                     ok = 1'b1;
                  end else begin
                     reach = reach_from(tgt);
                     if (!reach[src]) begin
                        prereqs[tgt][src] = 1'b1;
                        refresh_ready();
                        ok = 1'b1;
                     end
                  end
               end
            OP_MARK_RUNNING:
               if (slot_used[tgt] && slot_state[tgt] == ST_READY) begin
                  slot_state[tgt] = ST_RUNNING;
                  ok = 1'b1;
               end
            OP_MARK_DONE, OP_MARK_FAILED:
               if (slot_used[tgt] &&
                   (slot_state[tgt] == ST_READY || slot_state[tgt] == ST_RUNNING)) begin
                  slot_state[tgt] = (op == OP_MARK_DONE) ? ST_COMPLETED : ST_FAILED;
                  refresh_ready();
                  ok = 1'b1;
               end
            OP_RESET_FAILED:
               if (slot_used[tgt] && slot_state[tgt] == ST_FAILED) begin
                  slot_state[tgt] = ST_PENDING;
                  refresh_ready();
                  ok = 1'b1;
               end
            OP_REOPEN:
               if (slot_used[tgt]) begin
                  reach = reach_from(tgt);
                  for (int s = 0; s < NUM_SLOTS; s++)
                     if (slot_used[s] && reach[s]) slot_state[s] = ST_PENDING;
                  refresh_ready();
                  ok = 1'b1;
               end
            default: ;
         endcase
         o = '0;
         o.accepted = ok;
         for (int s = 0; s < NUM_SLOTS; s++) begin
            if (slot_used[s]) begin
               o.count = o.count + 1'b1;
               o.ready[s]  = slot_state[s] == ST_READY;
               o.failed[s] = slot_state[s] == ST_FAILED;
               if (slot_state[s] != ST_COMPLETED) o.unfinished = 1'b1;
            end
         end
         expected_q = {expected_q, o};
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("ERROR at %0t: %s", $realtime, msg);
      endfunction

      function void check_result(logic [RSP_W-1:0] d);
         outcome_type got, want;
         got = d;
         if (expected_q.size() == 0) begin
            flag($sformatf("result word with nothing expected: %h", d));
            return;
         end
         want = expected_q.pop_front();
         if (got.accepted !== want.accepted || got.ready !== want.ready ||
             got.failed !== want.failed || got.unfinished !== want.unfinished ||
             got.count !== want.count)
            flag($sformatf({"expected acc=%0b ready=%h failed=%h unfin=%0b count=%0d, ",
                            "got acc=%0b ready=%h failed=%h unfin=%0b count=%0d"},
                           want.accepted, want.ready, want.failed, want.unfinished,
                           want.count, got.accepted, got.ready, got.failed,
                           got.unfinished, got.count));
      endfunction
   endclass

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;

   dag_scoreboard sb = new();
   int            idle_pct    = 0;
   int            stall_pct   = 0;
   int            quiet_cycles = 0;

   task_dependency_scoreboard_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [REQ_W-1:0] pack_word(logic [OP_W-1:0] op, int tgt, int src,
                                                 logic [MASK_W-1:0] deps);
      return {3'b000, deps, src[SLOT_W-1:0], tgt[SLOT_W-1:0], op};
   endfunction

   // Random slot from a candidate set; any slot when the set is empty.
   function automatic int pick_from(logic [MASK_W-1:0] cand);
      int idx;
      idx = $urandom_range(NUM_SLOTS - 1);
      if (cand == 0) return idx;
      while (!cand[idx]) idx = (idx + 1) % NUM_SLOTS;
      return idx;
   endfunction

   function automatic logic [REQ_W-1:0] random_word();
      logic [MASK_W-1:0] live, deps;
      logic [REQ_W-1:0]  w;
      logic [OP_W-1:0]   op;
      int                pick, tgt, src;
      live = sb.valid_bits();
      pick = $urandom_range(99);
      tgt  = pick_from(live);
      src  = $urandom_range(NUM_SLOTS - 1);
      deps = $urandom;
      if (pick < 12) begin
         w = REQ_W'({$urandom, $urandom});
         w[REQ_W-1:45] = '0;
         return w;
      end else if (pick < 26) begin
         op   = OP_ADD_TASK;
         tgt  = pick_from(~live);
         deps = live & $urandom & ($urandom_range(1) ? $urandom : 32'hFFFF_FFFF);
         deps[tgt] = 1'b0;
      end else if (pick < 38) begin
         op  = OP_ADD_EDGE;
         src = pick_from(live & ~(32'd1 << tgt));
      end else if (pick < 52) begin
         op  = OP_MARK_RUNNING;
         tgt = pick_from(sb.slots_in(ST_READY));
      end else if (pick < 72) begin
         op  = OP_MARK_DONE;
         tgt = pick_from(sb.slots_in(ST_READY) | sb.slots_in(ST_RUNNING));
      end else if (pick < 80) begin
         op  = OP_MARK_FAILED;
         tgt = pick_from(sb.slots_in(ST_READY) | sb.slots_in(ST_RUNNING));
      end else if (pick < 90) begin
         op  = OP_RESET_FAILED;
         tgt = pick_from(sb.slots_in(ST_FAILED));
      end else begin
         op  = OP_REOPEN;
         tgt = pick_from(sb.slots_in(ST_COMPLETED));
      end
      return pack_word(op, tgt, src, deps);
   endfunction

   // Valid is only dropped when a gap is taken, so back-to-back words keep it high.
   task automatic send_word(logic [REQ_W-1:0] w);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(w);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part: rejections of every operation but mark failed, a short chain, and a reopen.
      send_word(pack_word(OP_UNDEFINED, 0, 0, '0));
      send_word(pack_word(OP_MARK_RUNNING, 3, 0, '0));
      send_word(pack_word(OP_ADD_TASK, 0, 0, '0));
      send_word(pack_word(OP_ADD_TASK, 31, 0, 32'h0000_0001));
      send_word(pack_word(OP_ADD_TASK, 5, 0, 32'h0000_0020));
      send_word(pack_word(OP_ADD_TASK, 6, 0, 32'h0000_0080));
      send_word(pack_word(OP_ADD_TASK, 0, 0, '0));
      send_word(pack_word(OP_ADD_TASK, 1, 0, 32'h8000_0001));
      send_word(pack_word(OP_ADD_EDGE, 1, 1, '0));
      send_word(pack_word(OP_ADD_EDGE, 1, 9, '0));
      send_word(pack_word(OP_ADD_EDGE, 31, 0, '0));
      send_word(pack_word(OP_ADD_EDGE, 0, 1, '0));
      send_word(pack_word(OP_MARK_DONE, 31, 0, '0));
      send_word(pack_word(OP_MARK_RUNNING, 0, 0, '0));
      send_word(pack_word(OP_MARK_RUNNING, 0, 0, '0));
      send_word(pack_word(OP_MARK_DONE, 0, 0, '0));
      send_word(pack_word(OP_MARK_FAILED, 31, 0, '0));
      send_word(pack_word(OP_RESET_FAILED, 31, 0, '0));
      send_word(pack_word(OP_RESET_FAILED, 31, 0, '0));
      send_word(pack_word(OP_MARK_DONE, 31, 0, '0));
      send_word(pack_word(OP_REOPEN, 0, 0, '0));
      send_word(pack_word(OP_REOPEN, 7, 0, '0));
      send_word(pack_word(OP_UNDEFINED, 31, 31, 32'hFFFF_FFFF));
      send_word(pack_word(OP_ADD_TASK, 2, 31, 32'hFFFF_FFFF));

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 71; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 71; end
            default: begin idle_pct = 30; stall_pct = 30; end
         endcase
         for (int i = 0; i < RANDOM_WORDS / 4; i++) send_word(random_word());
      end

      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
